[design/ibw_pkg.sv]
// Package for the interleaved bitstream writer.
// Holds the item codes, the result record and shared width constants.
// No dependencies.
package ibw_pkg;

  localparam int ADDR_WIDTH_DEF = 16;  // default address width
  localparam int ACC_WIDTH      = 32;  // bit accumulator width
  localparam int HALF_WIDTH     = 16;  // halfword written per slot
  localparam int FIELD_MAX      = 16;  // widest bit field per item
  localparam int FIFO_DEPTH     = 4;   // result queue entries
  localparam int FIFO_PTR_W     = 2;   // index bits of the result queue
  localparam int FIFO_CNT_W     = 3;   // fill count, holds FIFO_DEPTH

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_BITS   = 2'd1,
    REQ_BYTE   = 2'd2,
    REQ_FINISH = 2'd3
  } req_type_t;

  typedef struct packed {
    logic        ok;
    logic        write_en;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic        write_word;
    logic        last;
  } result_t;

  // Results produced by one accepted item, at most two.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

[design/interleaved_bitstream_writer.sv]
// Top level of the interleaved bitstream writer.
// Instantiates ibw_core (packing state) and ibw_out_fifo (result queue); uses ibw_pkg.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tuser req_type, tdata value + field_bits
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata write fields, tuser write_word, tlast
//   buf_len   in   buf_len_we                     buf_len_wdata
//
// One item per cycle is taken while s_axis_tready is high; its state update happens
// at the accept edge and its results enter the queue at that same edge, then reach
// m_axis in queue order. A finish item can give two results, so the output side then
// sets the long-run rate. s_axis_tready drops while the queue cannot take two more results.
// rst is synchronous; it restores the start state and sets buf_len to its maximum.
module interleaved_bitstream_writer #(
  parameter int ADDR_WIDTH = ibw_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        buf_len_we,
  input  logic [15:0] buf_len_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_value[15:0], field_bits[20:16], zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // ok[0], write_en[1], write_addr[17:2],
                                      // write_data[33:18], zero pad
  output logic [0:0]  m_axis_tuser,   // write_word[0]
  output logic        m_axis_tlast
);

  logic             accept;
  logic             room;
  ibw_pkg::push_t   push;
  ibw_pkg::result_t out_res;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid & room;

  ibw_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .buf_len_we    (buf_len_we),
    .buf_len_wdata (buf_len_wdata),
    .accept        (accept),
    .req_type      (s_axis_tuser),
    .data_value    (s_axis_tdata[15:0]),
    .field_bits    (s_axis_tdata[20:16]),
    .push          (push)
  );

  ibw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  always_comb begin
    m_axis_tdata = {6'd0, out_res.write_data, out_res.write_addr,
                    out_res.write_en, out_res.ok};
    m_axis_tuser = out_res.write_word;
    m_axis_tlast = out_res.last;
  end

endmodule

[design/ibw_core.sv]
// Bitstream packing state and the next-state logic for one item.
// Produces up to two results per accepted item.
// Depends on ibw_pkg.
module ibw_core #(
  parameter int ADDR_WIDTH = ibw_pkg::ADDR_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            buf_len_we,
  input  logic [15:0]     buf_len_wdata,
  input  logic            accept,
  input  logic [1:0]      req_type,
  input  logic [15:0]     data_value,
  input  logic [4:0]      field_bits,
  output ibw_pkg::push_t  push
);

  localparam int AW    = ADDR_WIDTH;
  localparam int CW    = AW + 1;
  localparam int NARROW = (AW < 16) ? AW : 16;

  logic [31:0]   bit_accum, bit_accum_next;
  logic [5:0]    pending_bits, pending_bits_next;
  logic [AW-1:0] slot_now_addr, slot_now_addr_next;
  logic [AW-1:0] slot_next_addr, slot_next_addr_next;
  logic          slot_next_valid, slot_next_valid_next;
  logic [CW-1:0] byte_cursor, byte_cursor_next;
  logic [AW-1:0] buf_len;

  logic [4:0]    n;
  logic [5:0]    total;
  logic [5:0]    shamt;
  logic [16:0]   field_mask;
  logic [15:0]   field;
  logic [31:0]   acc_add;
  logic [31:0]   acc_or;
  logic [CW:0]   cursor_p2;
  logic [CW:0]   buf_ext;
  logic [CW:0]   cursor_ext;
  ibw_pkg::result_t fail_res;
  ibw_pkg::req_type_t req;

  always_comb begin
    req        = ibw_pkg::req_type_t'(req_type);
    n          = (field_bits > 5'(ibw_pkg::FIELD_MAX)) ? 5'(ibw_pkg::FIELD_MAX) : field_bits;
    total      = pending_bits + {1'b0, n};
    shamt      = 6'(ibw_pkg::ACC_WIDTH) - total;
    field_mask = (17'd1 << n) - 17'd1;
    field      = data_value & field_mask[15:0];
    acc_add    = {16'd0, field} << shamt;
    acc_or     = bit_accum | acc_add;
    cursor_ext = {1'b0, byte_cursor};
    cursor_p2  = cursor_ext + (CW+1)'(2);
    buf_ext    = (CW+1)'(buf_len);
    fail_res   = '{ok: 1'b0, write_en: 1'b0, write_addr: 16'd0, write_data: 16'd0,
                   write_word: 1'b0, last: 1'b1};
  end

  always_comb begin
    bit_accum_next       = bit_accum;
    pending_bits_next    = pending_bits;
    slot_now_addr_next   = slot_now_addr;
    slot_next_addr_next  = slot_next_addr;
    slot_next_valid_next = slot_next_valid;
    byte_cursor_next     = byte_cursor;
    push.cnt             = 2'd1;
    push.res0            = fail_res;
    push.res1            = fail_res;

    unique case (req)
      ibw_pkg::REQ_START: begin
        bit_accum_next       = '0;
        pending_bits_next    = '0;
        slot_now_addr_next   = '0;
        slot_next_addr_next  = AW'(2);
        slot_next_valid_next = 1'b1;
        byte_cursor_next     = CW'(4);
        push.res0.ok         = 1'b1;
      end
      ibw_pkg::REQ_BITS: begin
        if (total <= 6'(ibw_pkg::ACC_WIDTH)) begin
          bit_accum_next    = acc_or;
          pending_bits_next = total;
          if (total > 6'(ibw_pkg::HALF_WIDTH)) begin
            if (slot_next_valid) begin
              // Spill the top halfword into the current slot, then rotate slots.
              bit_accum_next          = acc_or << ibw_pkg::HALF_WIDTH;
              pending_bits_next       = total - 6'(ibw_pkg::HALF_WIDTH);
              slot_now_addr_next      = slot_next_addr;
              push.res0.ok            = 1'b1;
              push.res0.write_en      = 1'b1;
              push.res0.write_addr    = 16'(slot_now_addr[NARROW-1:0]);
              push.res0.write_data    = acc_or[31:16];
              push.res0.write_word    = 1'b1;
              if (cursor_p2 > buf_ext) begin
                slot_next_valid_next = 1'b0;
                slot_next_addr_next  = '0;
              end else begin
                slot_next_addr_next  = byte_cursor[AW-1:0];
                byte_cursor_next     = cursor_p2[CW-1:0];
              end
            end
          end else begin
            push.res0.ok = 1'b1;
          end
        end
      end
      ibw_pkg::REQ_BYTE: begin
        if (cursor_ext < buf_ext) begin
          push.res0.ok         = 1'b1;
          push.res0.write_en   = 1'b1;
          push.res0.write_addr = 16'(byte_cursor[NARROW-1:0]);
          push.res0.write_data = {8'd0, data_value[7:0]};
          byte_cursor_next     = byte_cursor + CW'(1);
        end
      end
      ibw_pkg::REQ_FINISH: begin
        push.res0.ok         = 1'b1;
        push.res0.write_en   = 1'b1;
        push.res0.write_addr = 16'(slot_now_addr[NARROW-1:0]);
        push.res0.write_data = bit_accum[31:16];
        push.res0.write_word = 1'b1;
        push.res0.last       = ~slot_next_valid;
        if (slot_next_valid) begin
          // Zero the reserved word after the current one.
          push.cnt             = 2'd2;
          push.res1.ok         = 1'b1;
          push.res1.write_en   = 1'b1;
          push.res1.write_addr = 16'(slot_next_addr[NARROW-1:0]);
          push.res1.write_word = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accum       <= '0;
      pending_bits    <= '0;
      slot_now_addr   <= '0;
      slot_next_addr  <= AW'(2);
      slot_next_valid <= 1'b1;
      byte_cursor     <= CW'(4);
    end else if (accept) begin
      bit_accum       <= bit_accum_next;
      pending_bits    <= pending_bits_next;
      slot_now_addr   <= slot_now_addr_next;
      slot_next_addr  <= slot_next_addr_next;
      slot_next_valid <= slot_next_valid_next;
      byte_cursor     <= byte_cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= AW'({NARROW{1'b1}});
    end else if (buf_len_we) begin
      buf_len <= AW'(buf_len_wdata[NARROW-1:0]);
    end
  end

endmodule

[design/ibw_out_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one when out_ready is high.
// Depends on ibw_pkg.
module ibw_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  ibw_pkg::push_t    push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ibw_pkg::result_t  out_res
);

  ibw_pkg::result_t mem [ibw_pkg::FIFO_DEPTH];

  logic [ibw_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [ibw_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [ibw_pkg::FIFO_PTR_W-1:0] wr_ptr_p1;
  logic [ibw_pkg::FIFO_CNT_W-1:0] count;
  logic                           pop;

  always_comb begin
    out_valid = (count != '0);
    pop       = out_valid & out_ready;
    wr_ptr_p1 = wr_ptr + ibw_pkg::FIFO_PTR_W'(1);
    out_res   = mem[rd_ptr];
    // Leave space for the worst case of two results from the next item.
    room      = (count <= ibw_pkg::FIFO_CNT_W'(ibw_pkg::FIFO_DEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + ibw_pkg::FIFO_PTR_W'(1);
      end
      wr_ptr <= wr_ptr + ibw_pkg::FIFO_PTR_W'(push.cnt);
      count  <= count + ibw_pkg::FIFO_CNT_W'(push.cnt) - ibw_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule
